// ===== hdl/ilt_pkg.sv =====
// Shared types, constants and character codes for the INI line tokenizer.
package ilt_pkg;

    localparam int SECTION_CHARS = 32;
    localparam int KEY_CHARS     = 32;
    localparam int VALUE_CHARS   = 32;
    localparam int MAX_RESULTS   = 64;
    localparam int LEN_W         = 6;
    localparam int LINE_W        = 16;
    localparam int CNT_W         = 6;

    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LBRK  = 8'h5B;
    localparam logic [7:0] CHAR_RBRK  = 8'h5D;
    localparam logic [7:0] CHAR_EQ    = 8'h3D;

    localparam logic [1:0] KIND_SECTION = 2'd0;
    localparam logic [1:0] KIND_KEY     = 2'd1;
    localparam logic [1:0] KIND_VALUE   = 2'd2;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } ilt_in_t;

    typedef struct packed {
        logic [1:0]        token_kind;
        logic [7:0]        token_char;
        logic              char_present;
        logic [LINE_W-1:0] line_number;
        logic              token_end;
        logic              last_result;
    } ilt_out_t;

    typedef struct packed {
        logic              start;
        logic              emit_sec;
        logic              emit_kv;
        logic [LINE_W-1:0] line;
        logic [LEN_W-1:0]  sec_len;
        logic [LEN_W-1:0]  key_len;
        logic [LEN_W-1:0]  val_len;
    } ilt_plan_t;

endpackage

// ===== hdl/ilt_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module ilt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                     aclk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/ilt_scan.sv =====
// Byte scanner: mode flags, buffer lengths, line counter, buffer writes and burst plan.
module ilt_scan #(
    parameter int SECTION_CHARS = ilt_pkg::SECTION_CHARS,
    parameter int KEY_CHARS     = ilt_pkg::KEY_CHARS,
    parameter int VALUE_CHARS   = ilt_pkg::VALUE_CHARS,
    localparam int SEC_AW = (SECTION_CHARS > 1) ? $clog2(SECTION_CHARS) : 1,
    localparam int KEY_AW = (KEY_CHARS > 1) ? $clog2(KEY_CHARS) : 1,
    localparam int VAL_AW = (VALUE_CHARS > 1) ? $clog2(VALUE_CHARS) : 1
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               accept,
    input  ilt_pkg::ilt_in_t   in_data,
    output logic               sec_we,
    output logic [SEC_AW-1:0]  sec_waddr,
    output logic               key_we,
    output logic [KEY_AW-1:0]  key_waddr,
    output logic               val_we,
    output logic [VAL_AW-1:0]  val_waddr,
    output ilt_pkg::ilt_plan_t plan
);

    localparam int LW = ilt_pkg::LEN_W;
    localparam int NW = ilt_pkg::LINE_W;

    logic [LW-1:0] sec_len_reg, sec_len_next;
    logic [LW-1:0] key_len_reg, key_len_next;
    logic [LW-1:0] val_len_reg, val_len_next;
    logic [2:0]    flags_reg, flags_next;
    logic [NW-1:0] line_reg, line_next;

    logic [7:0] c;
    logic       is_ws;
    logic [2:0] f;
    logic       emit_sec;
    logic       emit_kv;

    assign c     = in_data.text_byte;
    assign is_ws = (c == ilt_pkg::CHAR_SPACE) ||
                   ((c >= ilt_pkg::CHAR_TAB) && (c <= ilt_pkg::CHAR_CR));

    always_comb begin
        sec_len_next = sec_len_reg;
        key_len_next = key_len_reg;
        val_len_next = val_len_reg;
        flags_next   = flags_reg;
        line_next    = line_reg;
        f            = flags_reg;
        emit_sec     = 1'b0;
        emit_kv      = 1'b0;
        sec_we       = 1'b0;
        key_we       = 1'b0;
        val_we       = 1'b0;
        sec_waddr    = sec_len_reg[SEC_AW-1:0];
        key_waddr    = key_len_reg[KEY_AW-1:0];
        val_waddr    = val_len_reg[VAL_AW-1:0];
        if (accept) begin
            if (c == ilt_pkg::CHAR_NL) begin
                emit_kv = flags_reg[2];
                if (line_reg != {NW{1'b1}}) begin
                    line_next = line_reg + NW'(1);
                end
                f = 3'b000;
            end else begin
                if (is_ws && !flags_reg[0]) begin
                    f = flags_reg;
                end else if (c == ilt_pkg::CHAR_LBRK) begin
                    sec_len_next = '0;
                    f[0] = 1'b1;
                end else if ((c == ilt_pkg::CHAR_RBRK) && flags_reg[0]) begin
                    f[0] = 1'b0;
                    emit_sec = 1'b1;
                end else if ((c == ilt_pkg::CHAR_EQ) && flags_reg[1]) begin
                    f[1] = 1'b0;
                    f[2] = 1'b1;
                    val_len_next = '0;
                end else begin
                    if (!(flags_reg[1] || flags_reg[2])) begin
                        key_len_next = '0;
                        f[1] = 1'b1;
                    end
                    if (f[0]) begin
                        if (sec_len_next < LW'(SECTION_CHARS)) begin
                            sec_we       = 1'b1;
                            sec_waddr    = sec_len_next[SEC_AW-1:0];
                            sec_len_next = sec_len_next + LW'(1);
                        end
                    end else if (f[1]) begin
                        if (key_len_next < LW'(KEY_CHARS)) begin
                            key_we       = 1'b1;
                            key_waddr    = key_len_next[KEY_AW-1:0];
                            key_len_next = key_len_next + LW'(1);
                        end
                    end else if (f[2]) begin
                        if (val_len_next < LW'(VALUE_CHARS)) begin
                            val_we       = 1'b1;
                            val_waddr    = val_len_next[VAL_AW-1:0];
                            val_len_next = val_len_next + LW'(1);
                        end
                    end
                end
                if (in_data.end_of_text) begin
                    emit_kv = f[2];
                end
            end
            flags_next = f;
            if (in_data.end_of_text) begin
                line_next  = '0;
                flags_next = 3'b000;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sec_len_reg <= '0;
            key_len_reg <= '0;
            val_len_reg <= '0;
            flags_reg   <= '0;
            line_reg    <= '0;
        end else begin
            sec_len_reg <= sec_len_next;
            key_len_reg <= key_len_next;
            val_len_reg <= val_len_next;
            flags_reg   <= flags_next;
            line_reg    <= line_next;
        end
    end

    assign plan.start    = accept && (emit_sec || emit_kv);
    assign plan.emit_sec = emit_sec;
    assign plan.emit_kv  = emit_kv;
    assign plan.line     = (line_reg == {NW{1'b1}}) ? line_reg : line_reg + NW'(1);
    assign plan.sec_len  = sec_len_reg;
    assign plan.key_len  = key_len_next;
    assign plan.val_len  = val_len_next;

endmodule

// ===== hdl/ilt_emit.sv =====
// Burst sequencer: reads the name buffers and streams one character per result.
module ilt_emit #(
    parameter int SECTION_CHARS = ilt_pkg::SECTION_CHARS,
    parameter int KEY_CHARS     = ilt_pkg::KEY_CHARS,
    parameter int VALUE_CHARS   = ilt_pkg::VALUE_CHARS,
    localparam int SEC_AW = (SECTION_CHARS > 1) ? $clog2(SECTION_CHARS) : 1,
    localparam int KEY_AW = (KEY_CHARS > 1) ? $clog2(KEY_CHARS) : 1,
    localparam int VAL_AW = (VALUE_CHARS > 1) ? $clog2(VALUE_CHARS) : 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  ilt_pkg::ilt_plan_t  plan,
    output logic                idle,
    output logic [SEC_AW-1:0]   sec_raddr,
    input  logic [7:0]          sec_rdata,
    output logic [KEY_AW-1:0]   key_raddr,
    input  logic [7:0]          key_rdata,
    output logic [VAL_AW-1:0]   val_raddr,
    input  logic [7:0]          val_rdata,
    output logic                m_valid,
    input  logic                m_ready,
    output ilt_pkg::ilt_out_t   m_data
);

    localparam int LW = ilt_pkg::LEN_W;
    localparam int NW = ilt_pkg::LINE_W;
    localparam int CW = ilt_pkg::CNT_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FETCH = 2'd1;
    localparam logic [1:0] ST_PUT   = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [1:0]    phase_reg, phase_next;
    logic [LW-1:0] idx_reg, idx_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          emit_kv_reg, emit_kv_next;
    logic [NW-1:0] line_reg, line_next;
    logic [LW-1:0] key_len_reg, key_len_next;
    logic [LW-1:0] val_len_reg, val_len_next;
    logic          m_valid_reg, m_valid_next;
    ilt_pkg::ilt_out_t m_data_reg, m_data_next;

    logic [LW-1:0] cur_len;
    logic [7:0]    cur_char;
    logic          empty;
    logic          tok_end;
    logic          has_next;
    logic          last;
    logic          load;
    logic [LW-1:0] rd_idx;

    always_comb begin
        case (phase_reg)
            ilt_pkg::KIND_SECTION: begin
                cur_len  = plan.sec_len;
                cur_char = sec_rdata;
            end
            ilt_pkg::KIND_KEY: begin
                cur_len  = key_len_reg;
                cur_char = key_rdata;
            end
            default: begin
                cur_len  = val_len_reg;
                cur_char = val_rdata;
            end
        endcase
    end

    assign empty    = (cur_len == '0);
    assign tok_end  = empty || ((idx_reg + LW'(1)) == cur_len);
    assign has_next = ((phase_reg == ilt_pkg::KIND_SECTION) && emit_kv_reg) ||
                      (phase_reg == ilt_pkg::KIND_KEY);
    assign last     = (tok_end && !has_next) || (cnt_reg == CW'(ilt_pkg::MAX_RESULTS - 1));
    assign load     = (state_reg == ST_PUT) && (!m_valid_reg || m_ready);
    assign rd_idx   = (load && !last) ? (tok_end ? '0 : idx_reg + LW'(1)) : idx_reg;

    assign sec_raddr = rd_idx[SEC_AW-1:0];
    assign key_raddr = rd_idx[KEY_AW-1:0];
    assign val_raddr = rd_idx[VAL_AW-1:0];

    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        idx_next     = idx_reg;
        cnt_next     = cnt_reg;
        emit_kv_next = emit_kv_reg;
        line_next    = line_reg;
        key_len_next = key_len_reg;
        val_len_next = val_len_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        case (state_reg)
            ST_IDLE: begin
                if (plan.start) begin
                    state_next   = ST_FETCH;
                    phase_next   = plan.emit_sec ? ilt_pkg::KIND_SECTION : ilt_pkg::KIND_KEY;
                    idx_next     = '0;
                    cnt_next     = '0;
                    emit_kv_next = plan.emit_kv;
                    line_next    = plan.line;
                    key_len_next = plan.key_len;
                    val_len_next = plan.val_len;
                end
            end
            ST_FETCH: begin
                state_next = ST_PUT;
            end
            ST_PUT: begin
                if (load) begin
                    m_valid_next             = 1'b1;
                    m_data_next.token_kind   = phase_reg;
                    m_data_next.token_char   = empty ? 8'h00 : cur_char;
                    m_data_next.char_present = !empty;
                    m_data_next.line_number  = line_reg;
                    m_data_next.token_end    = tok_end;
                    m_data_next.last_result  = last;
                    cnt_next                 = cnt_reg + CW'(1);
                    if (last) begin
                        state_next = ST_IDLE;
                    end else if (tok_end) begin
                        idx_next   = '0;
                        phase_next = (phase_reg == ilt_pkg::KIND_SECTION) ?
                                     ilt_pkg::KIND_KEY : ilt_pkg::KIND_VALUE;
                    end else begin
                        idx_next = idx_reg + LW'(1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        phase_reg   <= phase_next;
        idx_reg     <= idx_next;
        cnt_reg     <= cnt_next;
        emit_kv_reg <= emit_kv_next;
        line_reg    <= line_next;
        key_len_reg <= key_len_next;
        val_len_reg <= val_len_next;
        m_data_reg  <= m_data_next;
    end

    assign idle    = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== hdl/ini_line_tokenizer.sv =====
// Top level of the INI line tokenizer: scanner, three name buffers and burst sequencer.
// The tokenizer takes one text byte per transaction and streams section names, keys and
// values one character per result transaction. A byte that produces no result leaves the
// block ready, and the next byte can follow in the next cycle. A byte that closes a section
// name or a line with a value starts a burst of N results (at most 64); the input is held
// off through a fetch state, which covers the registered read of the buffer RAMs, and
// while the burst drains at full speed unless m_ready stalls it. The last result of a
// burst may still wait in the output register while the next byte is taken.
// The buffers need no clearing, so the block is ready as soon as reset is released.
module ini_line_tokenizer #(
    parameter int SECTION_CHARS = ilt_pkg::SECTION_CHARS,
    parameter int KEY_CHARS     = ilt_pkg::KEY_CHARS,
    parameter int VALUE_CHARS   = ilt_pkg::VALUE_CHARS
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ilt_pkg::ilt_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output ilt_pkg::ilt_out_t m_data
);

    localparam int SEC_AW = (SECTION_CHARS > 1) ? $clog2(SECTION_CHARS) : 1;
    localparam int KEY_AW = (KEY_CHARS > 1) ? $clog2(KEY_CHARS) : 1;
    localparam int VAL_AW = (VALUE_CHARS > 1) ? $clog2(VALUE_CHARS) : 1;

    logic               accept;
    logic               idle;
    ilt_pkg::ilt_plan_t plan;
    logic               sec_we, key_we, val_we;
    logic [SEC_AW-1:0]  sec_waddr, sec_raddr;
    logic [KEY_AW-1:0]  key_waddr, key_raddr;
    logic [VAL_AW-1:0]  val_waddr, val_raddr;
    logic [7:0]         sec_rdata, key_rdata, val_rdata;

    assign s_ready = idle;
    assign accept  = s_valid && idle;

    ilt_scan #(
        .SECTION_CHARS (SECTION_CHARS),
        .KEY_CHARS     (KEY_CHARS),
        .VALUE_CHARS   (VALUE_CHARS)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .in_data   (s_data),
        .sec_we    (sec_we),
        .sec_waddr (sec_waddr),
        .key_we    (key_we),
        .key_waddr (key_waddr),
        .val_we    (val_we),
        .val_waddr (val_waddr),
        .plan      (plan)
    );

    ilt_ram #(.WIDTH(8), .DEPTH(SECTION_CHARS)) u_sec_ram (
        .aclk  (aclk),
        .we    (sec_we),
        .waddr (sec_waddr),
        .wdata (s_data.text_byte),
        .raddr (sec_raddr),
        .rdata (sec_rdata)
    );

    ilt_ram #(.WIDTH(8), .DEPTH(KEY_CHARS)) u_key_ram (
        .aclk  (aclk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (s_data.text_byte),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    ilt_ram #(.WIDTH(8), .DEPTH(VALUE_CHARS)) u_val_ram (
        .aclk  (aclk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (s_data.text_byte),
        .raddr (val_raddr),
        .rdata (val_rdata)
    );

    ilt_emit #(
        .SECTION_CHARS (SECTION_CHARS),
        .KEY_CHARS     (KEY_CHARS),
        .VALUE_CHARS   (VALUE_CHARS)
    ) u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .plan      (plan),
        .idle      (idle),
        .sec_raddr (sec_raddr),
        .sec_rdata (sec_rdata),
        .key_raddr (key_raddr),
        .key_rdata (key_rdata),
        .val_raddr (val_raddr),
        .val_rdata (val_rdata),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ===== tb/tb_ini_line_tokenizer.sv =====
// Self-checking testbench for the INI line tokenizer with a built-in token predictor.
`timescale 1ns / 1ps

module tb_ini_line_tokenizer;

    localparam int unsigned CYCLE_LIMIT = 5_000_000;

    logic              aclk = 1'b1;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    ilt_pkg::ilt_in_t  s_data = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    ilt_pkg::ilt_out_t m_data;

    ini_line_tokenizer i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Tokenizer state as the predictor sees it.
    logic [7:0]                 sec_chars [ilt_pkg::SECTION_CHARS];
    logic [7:0]                 key_chars [ilt_pkg::KEY_CHARS];
    logic [7:0]                 val_chars [ilt_pkg::VALUE_CHARS];
    logic [ilt_pkg::LEN_W-1:0]  sec_len = '0;
    logic [ilt_pkg::LEN_W-1:0]  key_len = '0;
    logic [ilt_pkg::LEN_W-1:0]  val_len = '0;
    logic                       in_sec = 1'b0;
    logic                       in_key = 1'b0;
    logic                       in_val = 1'b0;
    logic [ilt_pkg::LINE_W-1:0] line_cnt = '0;

    ilt_pkg::ilt_out_t burst[$];
    ilt_pkg::ilt_out_t pending_tokens[$];
    ilt_pkg::ilt_in_t  text_queue[$];
    ilt_pkg::ilt_in_t  text_build[$];

    int unsigned cycles = 0;
    int unsigned errors = 0;
    int unsigned bytes_taken = 0;
    int unsigned bytes_seen = 0;
    int unsigned tokens_checked = 0;
    int unsigned cut_bursts = 0;
    bit          quiet = 1'b0;
    int          s_gap = 0;
    int          m_gap = 0;
    int          s_pct = 0;
    int          m_pct = 0;

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic logic [ilt_pkg::LINE_W-1:0] line_no();
        return (line_cnt == '1) ? line_cnt : line_cnt + 1'b1;
    endfunction

    function automatic void add_token(logic [1:0] kind, logic [7:0] ch, logic present,
                                      logic fin);
        ilt_pkg::ilt_out_t t;
        if (burst.size() >= ilt_pkg::MAX_RESULTS) begin
            return;
        end
        t.token_kind   = kind;
        t.token_char   = present ? ch : 8'h00;
        t.char_present = present;
        t.line_number  = line_no();
        t.token_end    = fin;
        t.last_result  = 1'b0;
        burst.push_back(t);
    endfunction

    function automatic void emit_name(logic [1:0] kind, logic [ilt_pkg::LEN_W-1:0] len);
        logic [7:0] ch;
        if (len == 0) begin
            add_token(kind, 8'h00, 1'b0, 1'b1);
            return;
        end
        for (int i = 0; i < len; i++) begin
            case (kind)
                ilt_pkg::KIND_SECTION: ch = sec_chars[i];
                ilt_pkg::KIND_KEY:     ch = key_chars[i];
                default:               ch = val_chars[i];
            endcase
            add_token(kind, ch, 1'b1, i == len - 1);
        end
    endfunction

    function automatic void close_line();
        if (in_val) begin
            emit_name(ilt_pkg::KIND_KEY, key_len);
            emit_name(ilt_pkg::KIND_VALUE, val_len);
        end
    endfunction

    function automatic void scan_char(logic [7:0] c);
        logic ws;
        ws = (c == ilt_pkg::CHAR_SPACE) || (c >= ilt_pkg::CHAR_TAB && c <= ilt_pkg::CHAR_CR);
        if (ws && !in_sec) begin
            return;
        end
        if (c == ilt_pkg::CHAR_LBRK) begin
            sec_len = '0;
            in_sec  = 1'b1;
            return;
        end
        if (c == ilt_pkg::CHAR_RBRK && in_sec) begin
            in_sec = 1'b0;
            emit_name(ilt_pkg::KIND_SECTION, sec_len);
            return;
        end
        if (c == ilt_pkg::CHAR_EQ && in_key) begin
            in_key  = 1'b0;
            val_len = '0;
            in_val  = 1'b1;
            return;
        end
        if (!in_key && !in_val) begin
            key_len = '0;
            in_key  = 1'b1;
        end
        if (in_sec) begin
            if (sec_len < ilt_pkg::SECTION_CHARS) begin
                sec_chars[sec_len] = c;
                sec_len++;
            end
        end else if (in_key) begin
            if (key_len < ilt_pkg::KEY_CHARS) begin
                key_chars[key_len] = c;
                key_len++;
            end
        end else if (in_val) begin
            if (val_len < ilt_pkg::VALUE_CHARS) begin
                val_chars[val_len] = c;
                val_len++;
            end
        end
    endfunction

    function automatic void tokenize_byte(ilt_pkg::ilt_in_t it);
        burst.delete();
        if (it.text_byte == ilt_pkg::CHAR_NL) begin
            close_line();
            if (line_cnt != '1) begin
                line_cnt++;
            end
            {in_sec, in_key, in_val} = 3'b000;
        end else begin
            scan_char(it.text_byte);
            if (it.end_of_text) begin
                close_line();
            end
        end
        if (it.end_of_text) begin
            line_cnt = '0;
            {in_sec, in_key, in_val} = 3'b000;
        end
        if (burst.size() == ilt_pkg::MAX_RESULTS) begin
            cut_bursts++;
        end
        if (burst.size() != 0) begin
            burst[burst.size() - 1].last_result = 1'b1;
        end
        foreach (burst[i]) begin
            pending_tokens.push_back(burst[i]);
        end
    endfunction

    function automatic void check_field(string name, int unsigned want, logic [15:0] got);
        if (got !== want[15:0]) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    function automatic void check_token(ilt_pkg::ilt_out_t want, ilt_pkg::ilt_out_t got);
        check_field("token_kind", want.token_kind, got.token_kind);
        check_field("token_char", want.token_char, got.token_char);
        check_field("char_present", want.char_present, got.char_present);
        check_field("line_number", want.line_number, got.line_number);
        check_field("token_end", want.token_end, got.token_end);
        check_field("last_result", want.last_result, got.last_result);
    endfunction

    function automatic int pick_idle_pct();
        case ($urandom_range(0, 4))
            0, 1:    return 0;
            2:       return 5;
            3:       return 20;
            default: return 45;
        endcase
    endfunction

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            tokenize_byte(s_data);
            bytes_taken++;
        end
        if (aresetn && m_valid && m_ready) begin
            tokens_checked++;
            if (pending_tokens.size() == 0) begin
                errors++;
                $display("%0t: unexpected result transaction, expected none, got %h",
                         $time, m_data);
            end else begin
                check_token(pending_tokens.pop_front(), m_data);
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycles, pending_tokens.size());
            $display("FAIL");
            $finish;
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || bytes_seen != bytes_taken) begin
            if (s_gap > 0) begin
                s_gap--;
                s_valid <= 1'b0;
            end else if (text_queue.size() != 0 && !quiet && $urandom_range(0, 99) < s_pct) begin
                s_gap = $urandom_range(0, 7);
                s_valid <= 1'b0;
            end else if (text_queue.size() != 0) begin
                s_data  <= text_queue.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
        bytes_seen = bytes_taken;
        if (cycles % 256 == 0) begin
            s_pct = quiet ? 0 : pick_idle_pct();
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (m_gap > 0) begin
            m_gap--;
            m_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 99) < m_pct) begin
            m_gap = $urandom_range(0, 7);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
        if (cycles % 256 == 128) begin
            m_pct = quiet ? 0 : pick_idle_pct();
        end
    end

    function automatic void put_char(logic [7:0] c);
        ilt_pkg::ilt_in_t b;
        b.text_byte   = c;
        b.end_of_text = 1'b0;
        text_build.push_back(b);
    endfunction

    function automatic void put_str(string s);
        for (int i = 0; i < s.len(); i++) begin
            put_char(s[i]);
        end
    endfunction

    function automatic void finish_text(bit mark_end);
        if (mark_end && text_build.size() != 0) begin
            text_build[text_build.size() - 1].end_of_text = 1'b1;
        end
        foreach (text_build[i]) begin
            text_queue.push_back(text_build[i]);
        end
        text_build.delete();
    endfunction

    function automatic logic [7:0] rand_ws();
        case ($urandom_range(0, 5))
            1:       return ilt_pkg::CHAR_TAB;
            2:       return 8'h0B;
            3:       return 8'h0C;
            4:       return ilt_pkg::CHAR_CR;
            default: return ilt_pkg::CHAR_SPACE;
        endcase
    endfunction

    function automatic logic [7:0] rand_name_char();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(0, 255));
        end while (c == ilt_pkg::CHAR_SPACE ||
                   (c >= ilt_pkg::CHAR_TAB && c <= ilt_pkg::CHAR_CR) ||
                   c == ilt_pkg::CHAR_LBRK || c == ilt_pkg::CHAR_RBRK ||
                   c == ilt_pkg::CHAR_EQ);
        return c;
    endfunction

    function automatic int pick_len();
        case ($urandom_range(0, 19))
            0:       return 0;
            1:       return $urandom_range(30, 40);
            default: return $urandom_range(1, 6);
        endcase
    endfunction

    function automatic void maybe_ws();
        if ($urandom_range(0, 2) == 0) begin
            put_char(rand_ws());
        end
    endfunction

    function automatic void put_name(int n, bit spaced);
        for (int i = 0; i < n; i++) begin
            if (spaced && $urandom_range(0, 7) == 0) begin
                put_char(rand_ws());
            end else begin
                put_char(rand_name_char());
            end
        end
    endfunction

    function automatic void gen_random_text();
        int lines;
        int kind;
        lines = $urandom_range(1, 5);
        for (int l = 0; l < lines; l++) begin
            kind = $urandom_range(0, 9);
            if (kind <= 2) begin
                maybe_ws();
                put_char(ilt_pkg::CHAR_LBRK);
                put_name(pick_len(), 1'b1);
                put_char(ilt_pkg::CHAR_RBRK);
                maybe_ws();
            end else if (kind <= 7) begin
                maybe_ws();
                put_name(pick_len(), 1'b0);
                maybe_ws();
                put_char(ilt_pkg::CHAR_EQ);
                maybe_ws();
                put_name(pick_len(), 1'b0);
                maybe_ws();
            end else if (kind == 8) begin
                for (int i = $urandom_range(0, 8); i > 0; i--) begin
                    put_char(8'($urandom_range(0, 255)));
                end
            end else begin
                put_name($urandom_range(1, 4), 1'b0);
                put_char(ilt_pkg::CHAR_LBRK);
                put_name($urandom_range(0, 3), 1'b1);
                if ($urandom_range(0, 1)) begin
                    put_char(ilt_pkg::CHAR_RBRK);
                end
                put_char(ilt_pkg::CHAR_EQ);
                put_name($urandom_range(0, 4), 1'b0);
            end
            if (l < lines - 1 || text_build.size() == 0 || $urandom_range(0, 1)) begin
                put_char(ilt_pkg::CHAR_NL);
            end
        end
        finish_text(1'b1);
    endfunction

    task automatic wait_drained();
        while (text_queue.size() != 0 || s_valid || pending_tokens.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        put_str("[]k=\n]=\n");
        finish_text(1'b0);
        put_char(8'h00);
        put_char(8'hFF);
        put_char(ilt_pkg::CHAR_EQ);
        put_char(8'h80);
        finish_text(1'b1);
        put_str(" \t\r[ x]");
        put_char(ilt_pkg::CHAR_NL);
        finish_text(1'b1);
        put_str("a[b]=c");
        finish_text(1'b1);
        wait_drained();

        // A closing bracket on the last byte of a line with a value overruns the burst.
        put_name(33, 1'b0);
        put_char(ilt_pkg::CHAR_EQ);
        put_name(33, 1'b0);
        put_char(ilt_pkg::CHAR_LBRK);
        put_name(33, 1'b1);
        put_char(ilt_pkg::CHAR_RBRK);
        finish_text(1'b1);
        while (bytes_taken + text_queue.size() < 330) begin
            gen_random_text();
            if (text_queue.size() > 64) begin
                wait (text_queue.size() < 32);
            end
        end
        wait_drained();

        quiet = 1'b1;
        while (bytes_taken + text_queue.size() < 410) begin
            gen_random_text();
        end
        wait_drained();
        repeat (80) @(posedge aclk);

        $display("Took %0d text bytes, including corner-case texts and oversized names.",
                 bytes_taken);
        $display("Checked %0d result transactions; %0d bursts were cut at %0d results.",
                 tokens_checked, cut_bursts, ilt_pkg::MAX_RESULTS);
        if (errors == 0 && pending_tokens.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
